[rtl/crt_pkg.sv]
// Shared types and fixed widths for the Catmull-Rom tessellator.
package crt_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int CNT_W  = 7;
    localparam int NN_W   = 14;
    localparam int N3_W   = 21;
    localparam int NUM_W  = 26;
    localparam int FRAC_W = 16;
    localparam int DIVD_W = 45;
    localparam int Q_W    = 18;
    localparam int W_W    = Q_W + 1;
    localparam int QC_W   = 5;
    localparam logic [CNT_W-1:0] SEG_COUNT_RESET = 7'd8;

    typedef struct packed {
        logic             accept;
        logic             setup1;
        logic             setup2;
        logic             prep1;
        logic             prep2;
        logic             prep3;
        logic             div_load;
        logic             div_step;
        logic             fix;
        logic             mul;
        logic             sum;
        logic             advance;
        logic [CNT_W-1:0] j;
        logic [CNT_W-1:0] n;
    } crt_cmd_t;

    typedef struct packed {
        logic span_go;
    } crt_status_t;

endpackage

[rtl/crt_ctrl.sv]
// Sequencer for the tessellator: handshakes, segment counter and divider steps.
module crt_ctrl
    import crt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  crt_status_t      status,
    output crt_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP1, S_SETUP2, S_PREP1, S_PREP2, S_PREP3,
        S_LOAD, S_DIV, S_FIX, S_MUL, S_SUM, S_WAIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] seg_count_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] j_reg;
    logic [QC_W-1:0]  div_cnt_reg;
    logic [CNT_W-1:0] n_eff;

    always_comb
    begin
        if (seg_count_reg == '0)
            n_eff = CNT_W'(1);
        else if (int'(seg_count_reg) > MAX_SEGMENTS)
            n_eff = CNT_W'(MAX_SEGMENTS);
        else
            n_eff = seg_count_reg;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_WAIT);

    always_comb
    begin
        cmd          = '0;
        cmd.accept   = in_valid && (state_reg == S_IDLE);
        cmd.setup1   = (state_reg == S_SETUP1);
        cmd.setup2   = (state_reg == S_SETUP2);
        cmd.prep1    = (state_reg == S_PREP1);
        cmd.prep2    = (state_reg == S_PREP2);
        cmd.prep3    = (state_reg == S_PREP3);
        cmd.div_load = (state_reg == S_LOAD);
        cmd.div_step = (state_reg == S_DIV);
        cmd.fix      = (state_reg == S_FIX);
        cmd.mul      = (state_reg == S_MUL);
        cmd.sum      = (state_reg == S_SUM);
        cmd.advance  = (state_reg == S_WAIT) && out_ready;
        cmd.j        = j_reg;
        cmd.n        = n_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seg_count_reg <= SEG_COUNT_RESET;
            n_reg         <= CNT_W'(1);
            j_reg         <= CNT_W'(1);
            div_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                seg_count_reg <= cfg_wr_data;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && status.span_go)
                    begin
                        n_reg     <= n_eff;
                        j_reg     <= CNT_W'(1);
                        state_reg <= S_SETUP1;
                    end
                end
                S_SETUP1: state_reg <= S_SETUP2;
                S_SETUP2: state_reg <= S_PREP1;
                S_PREP1:  state_reg <= S_PREP2;
                S_PREP2:  state_reg <= S_PREP3;
                S_PREP3:  state_reg <= S_LOAD;
                S_LOAD:
                begin
                    div_cnt_reg <= '0;
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_cnt_reg == QC_W'(Q_W - 1))
                        state_reg <= S_FIX;
                    else
                        div_cnt_reg <= div_cnt_reg + QC_W'(1);
                end
                S_FIX: state_reg <= S_MUL;
                S_MUL: state_reg <= S_SUM;
                S_SUM: state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (out_ready)
                    begin
                        if (j_reg == n_reg)
                            state_reg <= S_IDLE;
                        else
                        begin
                            j_reg     <= j_reg + CNT_W'(1);
                            state_reg <= S_PREP1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_ready_valid_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a segment is pending");

    a_span_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && status.span_go) |=> (state_reg == S_SETUP1))
        else $error("span did not start after full window");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_cnt_reg < QC_W'(Q_W)))
        else $error("divider step count overran");

    a_next_seg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT && out_ready && j_reg != n_reg) |=> (state_reg == S_PREP1))
        else $error("next segment not started");

    a_j_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (j_reg <= n_reg && j_reg != '0))
        else $error("segment index out of range");

endmodule

[rtl/crt_datapath.sv]
// Window, basis weight dividers, dot products and output registers.
module crt_datapath
    import crt_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  crt_cmd_t                     cmd,
    output crt_status_t                  status,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic                         in_start,
    output logic signed [COORD_BITS-1:0] seg_start_x,
    output logic signed [COORD_BITS-1:0] seg_start_y,
    output logic signed [COORD_BITS-1:0] seg_end_x,
    output logic signed [COORD_BITS-1:0] seg_end_y,
    output logic                         last_segment
);

    localparam int PW     = COORD_BITS + W_W;
    localparam int ACC_W  = PW + 2;
    localparam int SH_W   = ACC_W - FRAC_W;

    logic signed [COORD_BITS-1:0] win_x_reg [3];
    logic signed [COORD_BITS-1:0] win_y_reg [3];
    logic signed [COORD_BITS-1:0] win_x_next [3];
    logic signed [COORD_BITS-1:0] win_y_next [3];
    logic [1:0]                   held_reg;
    logic [1:0]                   held_eff;
    logic [1:0]                   held_next;

    logic signed [COORD_BITS-1:0] px_reg [4];
    logic signed [COORD_BITS-1:0] py_reg [4];

    logic [NN_W-1:0]  nn_reg;
    logic [N3_W-1:0]  n3_reg;
    logic [NN_W-1:0]  j2_reg;
    logic [N3_W-1:0]  jnn_reg;
    logic [N3_W-1:0]  j3_reg;
    logic [N3_W-1:0]  j2n_reg;
    logic signed [NUM_W-1:0] num_reg [4];
    logic signed [NUM_W-1:0] num_next [4];
    logic signed [NUM_W-1:0] j3s, j2ns, jnns, n3s;

    logic [DIVD_W-1:0]       rem_reg [4];
    logic [DIVD_W-1:0]       dsh_reg;
    logic [Q_W-1:0]          q_reg [4];
    logic                    neg_reg [4];
    logic signed [DIVD_W-1:0] divd [4];
    logic signed [W_W-1:0]   w_reg [4];

    logic signed [PW-1:0]    prod_x_reg [4];
    logic signed [PW-1:0]    prod_y_reg [4];
    logic signed [ACC_W-1:0] acc_x, acc_y;
    logic signed [COORD_BITS-1:0] sat_x, sat_y;

    logic signed [COORD_BITS-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic                         last_reg;

    function automatic logic signed [COORD_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc);
        logic signed [SH_W-1:0] sh;
        logic                   fits;
        sh   = SH_W'(acc >>> FRAC_W);
        fits = (&sh[SH_W-1:COORD_BITS-1]) || !(|sh[SH_W-1:COORD_BITS-1]);
        if (fits)
            return sh[COORD_BITS-1:0];
        else if (sh[SH_W-1])
            return {1'b1, {(COORD_BITS-1){1'b0}}};
        else
            return {1'b0, {(COORD_BITS-1){1'b1}}};
    endfunction

    assign held_eff       = in_start ? 2'd0 : held_reg;
    assign status.span_go = (held_eff == 2'd3);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_x_next[i] = in_start ? '0 : win_x_reg[i];
            win_y_next[i] = in_start ? '0 : win_y_reg[i];
        end
        if (held_eff == 2'd3)
        begin
            win_x_next[0] = win_x_reg[1];
            win_x_next[1] = win_x_reg[2];
            win_x_next[2] = in_x;
            win_y_next[0] = win_y_reg[1];
            win_y_next[1] = win_y_reg[2];
            win_y_next[2] = in_y;
            held_next     = 2'd3;
        end
        else
        begin
            win_x_next[held_eff] = in_x;
            win_y_next[held_eff] = in_y;
            held_next            = held_eff + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                win_x_reg[i] <= '0;
                win_y_reg[i] <= '0;
            end
        end
        else if (cmd.accept)
        begin
            held_reg <= held_next;
            for (int i = 0; i < 3; i++)
            begin
                win_x_reg[i] <= win_x_next[i];
                win_y_reg[i] <= win_y_next[i];
            end
        end
    end

    always_comb
    begin
        j3s  = $signed(NUM_W'(j3_reg));
        j2ns = $signed(NUM_W'(j2n_reg));
        jnns = $signed(NUM_W'(jnn_reg));
        n3s  = $signed(NUM_W'(n3_reg));
        num_next[0] = (j2ns <<< 1) - j3s - jnns;
        num_next[1] = (j3s <<< 1) + j3s - (j2ns <<< 2) - j2ns + (n3s <<< 1);
        num_next[2] = (j2ns <<< 2) + jnns - (j3s <<< 1) - j3s;
        num_next[3] = j3s - j2ns;
        for (int k = 0; k < 4; k++)
            divd[k] = (DIVD_W'(num_reg[k]) <<< (FRAC_W + 1))
                    + $signed(DIVD_W'({n3_reg, 1'b0}));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && status.span_go)
        begin
            for (int i = 0; i < 3; i++)
            begin
                px_reg[i] <= win_x_reg[i];
                py_reg[i] <= win_y_reg[i];
            end
            px_reg[3] <= in_x;
            py_reg[3] <= in_y;
            sx_reg    <= win_x_reg[1];
            sy_reg    <= win_y_reg[1];
        end
        if (cmd.setup1)
            nn_reg <= NN_W'(cmd.n) * NN_W'(cmd.n);
        if (cmd.setup2)
            n3_reg <= N3_W'(nn_reg) * N3_W'(cmd.n);
        if (cmd.prep1)
        begin
            j2_reg  <= NN_W'(cmd.j) * NN_W'(cmd.j);
            jnn_reg <= N3_W'(nn_reg) * N3_W'(cmd.j);
        end
        if (cmd.prep2)
        begin
            j3_reg  <= N3_W'(j2_reg) * N3_W'(cmd.j);
            j2n_reg <= N3_W'(j2_reg) * N3_W'(cmd.n);
        end
        if (cmd.prep3)
            for (int k = 0; k < 4; k++)
                num_reg[k] <= num_next[k];
        if (cmd.div_load)
        begin
            dsh_reg <= DIVD_W'({n3_reg, 2'b00}) << (Q_W - 1);
            for (int k = 0; k < 4; k++)
            begin
                neg_reg[k] <= divd[k][DIVD_W-1];
                rem_reg[k] <= divd[k][DIVD_W-1] ? DIVD_W'(-divd[k]) : DIVD_W'(divd[k]);
                q_reg[k]   <= '0;
            end
        end
        if (cmd.div_step)
        begin
            dsh_reg <= dsh_reg >> 1;
            for (int k = 0; k < 4; k++)
            begin
                if (rem_reg[k] >= dsh_reg)
                begin
                    rem_reg[k] <= rem_reg[k] - dsh_reg;
                    q_reg[k]   <= {q_reg[k][Q_W-2:0], 1'b1};
                end
                else
                    q_reg[k] <= {q_reg[k][Q_W-2:0], 1'b0};
            end
        end
        if (cmd.fix)
            for (int k = 0; k < 4; k++)
            begin
                if (!neg_reg[k])
                    w_reg[k] <= $signed({1'b0, q_reg[k]});
                else if (rem_reg[k] != '0)
                    w_reg[k] <= -$signed({1'b0, q_reg[k]}) - W_W'(1);
                else
                    w_reg[k] <= -$signed({1'b0, q_reg[k]});
            end
        if (cmd.mul)
            for (int k = 0; k < 4; k++)
            begin
                prod_x_reg[k] <= PW'(px_reg[k]) * PW'(w_reg[k]);
                prod_y_reg[k] <= PW'(py_reg[k]) * PW'(w_reg[k]);
            end
        if (cmd.sum)
        begin
            ex_reg   <= sat_x;
            ey_reg   <= sat_y;
            last_reg <= (cmd.j == cmd.n);
        end
        if (cmd.advance)
        begin
            sx_reg <= ex_reg;
            sy_reg <= ey_reg;
        end
    end

    always_comb
    begin
        acc_x = ACC_W'(1) <<< (FRAC_W - 1);
        acc_y = ACC_W'(1) <<< (FRAC_W - 1);
        for (int k = 0; k < 4; k++)
        begin
            acc_x = acc_x + ACC_W'(prod_x_reg[k]);
            acc_y = acc_y + ACC_W'(prod_y_reg[k]);
        end
        sat_x = round_sat(acc_x);
        sat_y = round_sat(acc_y);
    end

    assign seg_start_x  = sx_reg;
    assign seg_start_y  = sy_reg;
    assign seg_end_x    = ex_reg;
    assign seg_end_y    = ey_reg;
    assign last_segment = last_reg;

endmodule

[rtl/catmull_rom_tessellator_unit.sv]
// Top level of the uniform Catmull-Rom spline tessellator.
// Control points enter one beat at a time; once three points of the current curve are held,
// each new point produces segment_count line segments (clamped to 1..MAX_SEGMENTS) along the
// span between the middle two points. The block takes one point at a time: a point that only
// fills the window is taken in IDLE, and a point that completes a span holds the input off
// until its last segment is accepted; each segment is formed with the 18-step shared-shift
// restoring dividers that form its four basis weights.
module catmull_rom_tessellator_unit
    import crt_pkg::*;
#(
    parameter int COORD_BITS   = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_wr_en,
    input  logic [CNT_W-1:0]                           cfg_wr_data,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // point_x, point_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]          s_axis_tdata,
    // start_curve
    input  logic                                       s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y
    output logic [((4*COORD_BITS+7)/8)*8-1:0]          m_axis_tdata,
    output logic                                       m_axis_tlast
);

    localparam int OUT_W = ((4*COORD_BITS+7)/8)*8;

    crt_cmd_t                     cmd;
    crt_status_t                  status;
    logic signed [COORD_BITS-1:0] sx, sy, ex, ey;

    crt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .status     (status),
        .cmd        (cmd)
    );

    crt_datapath #(
        .COORD_BITS(COORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_x        (s_axis_tdata[COORD_BITS-1:0]),
        .in_y        (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_start    (s_axis_tuser),
        .seg_start_x (sx),
        .seg_start_y (sy),
        .seg_end_x   (ex),
        .seg_end_y   (ey),
        .last_segment(m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'({ey, ex, sy, sx});

endmodule

[bench/catmull_rom_tessellator_unit_test.sv]
// Self-checking testbench for the Catmull-Rom tessellator: random points, idling and checks.
module catmull_rom_tessellator_unit_test;
    import crt_pkg::*;

    typedef struct {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic               last;
    } segment_t;

    class segment_scoreboard;
        segment_t          pending[$];
        int                errors;
        logic [CNT_W-1:0]  seg_count;
        longint            wx[3];
        longint            wy[3];
        int                held;

        function void clear();
            seg_count = SEG_COUNT_RESET;
            wx = '{0, 0, 0};
            wy = '{0, 0, 0};
            held = 0;
            errors = 0;
        endfunction

        function longint fdiv(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && a < 0)
                q = q - 1;
            return q;
        endfunction

        function logic signed [15:0] blend(longint p0, longint p1, longint p2, longint p3,
                                           longint w0, longint w1, longint w2, longint w3);
            longint acc;
            acc = fdiv(p0 * w0 + p1 * w1 + p2 * w2 + p3 * w3 + 32768, 65536);
            if (acc > 32767)
                acc = 32767;
            if (acc < -32768)
                acc = -32768;
            return acc[15:0];
        endfunction

        function void note_point(logic signed [15:0] px, logic signed [15:0] py, logic start);
            longint n;
            longint d;
            longint j;
            longint w0;
            longint w1;
            longint w2;
            longint w3;
            segment_t s;
            if (start)
            begin
                wx = '{0, 0, 0};
                wy = '{0, 0, 0};
                held = 0;
            end
            if (held < 3)
            begin
                wx[held] = px;
                wy[held] = py;
                held++;
                return;
            end
            n = seg_count;
            if (n < 1)
                n = 1;
            if (n > MAX_SEGMENTS)
                n = MAX_SEGMENTS;
            d = 2 * n * n * n;
            s.sx = wx[1][15:0];
            s.sy = wy[1][15:0];
            for (j = 1; j <= n; j++)
            begin
                w0 = fdiv((-j*j*j + 2*j*j*n - j*n*n) * 131072 + d, 2 * d);
                w1 = fdiv((3*j*j*j - 5*j*j*n + 2*n*n*n) * 131072 + d, 2 * d);
                w2 = fdiv((-3*j*j*j + 4*j*j*n + j*n*n) * 131072 + d, 2 * d);
                w3 = fdiv((j*j*j - j*j*n) * 131072 + d, 2 * d);
                s.ex = blend(wx[0], wx[1], wx[2], px, w0, w1, w2, w3);
                s.ey = blend(wy[0], wy[1], wy[2], py, w0, w1, w2, w3);
                s.last = (j == n);
                pending = {pending, s};
                s.sx = s.ex;
                s.sy = s.ey;
            end
            wx[0] = wx[1];
            wx[1] = wx[2];
            wx[2] = px;
            wy[0] = wy[1];
            wy[1] = wy[2];
            wy[2] = py;
        endfunction

        function void check_segment(logic [63:0] data, logic last);
            segment_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected segment %h last %b", $time, data, last);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data !== {e.ey, e.ex, e.sy, e.sx} || last !== e.last)
            begin
                $display("%0t: expected %h last %b, actual %h last %b", $time,
                         {e.ey, e.ex, e.sy, e.sx}, e.last, data, last);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [31:0]      s_axis_tdata;
    logic             s_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [63:0]      m_axis_tdata;
    logic             m_axis_tlast;

    segment_scoreboard sb;
    int  send_idle;
    int  recv_idle;
    bit  hold_off;
    int  quiet;

    catmull_rom_tessellator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_point(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tuser);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_segment(m_axis_tdata, m_axis_tlast);
    end

    always @(negedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 40000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The beat stays offered after acceptance until the next call or an explicit drop,
    // so that back-to-back points never assign the valid twice in one step.
    task automatic send_point(logic [15:0] px, logic [15:0] py, logic start);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px};
        s_axis_tuser  <= start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_count(logic [CNT_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        sb.seg_count = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_curve(int points);
        for (int i = 0; i < points; i++)
        begin
            case ($urandom_range(3))
                0: send_point(16'($urandom), 16'($urandom), i == 0);
                1: send_point(16'($urandom_range(1000) - 500),
                              16'($urandom_range(1000) - 500), i == 0);
                2: send_point($urandom_range(1) ? 16'h7fff : 16'h8000,
                              $urandom_range(1) ? 16'h7fff : 16'h8000, i == 0);
                default: send_point(16'($urandom_range(40000) - 20000), 16'($urandom), i == 0);
            endcase
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        hold_off = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: window filling, extremes, restart, reset-count curve, count clamping.
        send_point(16'h7fff, 16'h8000, 1'b0);
        send_point(16'h8000, 16'h7fff, 1'b0);
        send_point(16'h7fff, 16'h7fff, 1'b0);
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h0000, 16'hffff, 1'b0);
        send_point(16'h0001, 16'h0002, 1'b1);
        send_point(16'h0010, 16'h0020, 1'b0);
        send_point(16'hfff0, 16'h0100, 1'b0);
        send_point(16'h0100, 16'hff00, 1'b0);
        write_count(7'd0);
        send_point(16'h1234, 16'h8765, 1'b0);
        write_count(7'd127);
        send_point(16'h8000, 16'h7fff, 1'b0);
        write_count(7'd64);
        send_point(16'h0005, 16'hfffb, 1'b0);
        write_count(7'd1);
        send_point(16'h7fff, 16'h0000, 1'b1);
        send_point(16'h8000, 16'h0000, 1'b0);
        send_point(16'h7fff, 16'h0000, 1'b0);
        send_point(16'h8000, 16'h0000, 1'b0);
        write_count(7'd3);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle = (phase == 1 || phase == 3) ? (phase == 1 ? 58 : 23) : 0;
            recv_idle = (phase == 2 || phase == 3) ? (phase == 2 ? 58 : 23) : 0;
            for (int c = 0; c < 5; c++)
                random_curve($urandom_range(7, 4));
            write_count((phase == 2) ? 7'd65 : CNT_W'($urandom_range(8, 1)));
        end

        // Long receiver hold-off while points keep arriving.
        send_idle = 0;
        recv_idle = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(negedge clk);
                hold_off = 1'b0;
            end
            random_curve(6);
        join
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
